// File: rtl/core/http_message_framer_macros.svh
// assertion macros shared by the framer checker
// no dependencies
`ifndef HTTP_MESSAGE_FRAMER_MACROS_SVH
`define HTTP_MESSAGE_FRAMER_MACROS_SVH

// implication in the same cycle
`define HMF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication in the following cycle
`define HMF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/hmf_pkg.sv
// types, codes and constant tables of the http message framer
// no dependencies
package hmf_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [3:0] KEY_LEN = 4'd15;
   localparam logic [7:0] CHAR_CR = 8'd13;
   localparam logic [7:0] CHAR_LF = 8'd10;
   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_ZERO = 8'd48;
   localparam logic [7:0] CHAR_KEY_START = 8'h63;

   typedef struct packed {
      logic [7:0] data;
      logic [7:0] lower;
      logic       is_digit;
      logic [3:0] digit;
      logic       is_space;
      logic       is_cr;
      logic       is_lf;
      logic       is_key_start;
   } class_type;

   typedef enum logic [1:0] {
      PH_HEADER = 2'b01,
      PH_BODY   = 2'b10
   } phase_type;

   typedef enum logic [3:0] {
      VS_NO_KEY = 4'b0001,
      VS_SKIP   = 4'b0010,
      VS_DIGITS = 4'b0100,
      VS_DONE   = 4'b1000
   } value_state_type;

   // "content-length:" in lower case
   function automatic logic [7:0] key_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:    c = 8'h63;
         4'd1:    c = 8'h6f;
         4'd2:    c = 8'h6e;
         4'd3:    c = 8'h74;
         4'd4:    c = 8'h65;
         4'd5:    c = 8'h6e;
         4'd6:    c = 8'h74;
         4'd7:    c = 8'h2d;
         4'd8:    c = 8'h6c;
         4'd9:    c = 8'h65;
         4'd10:   c = 8'h6e;
         4'd11:   c = 8'h67;
         4'd12:   c = 8'h74;
         4'd13:   c = 8'h68;
         4'd14:   c = 8'h3a;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// File: rtl/core/http_message_framer.sv
// top level of the http message framer
// depends on hmf_pkg, hmf_front, hmf_queue, hmf_back
//
// Frames an HTTP byte stream by Content-Length: every byte that goes in comes
// out once, tagged header or body, with message_end on the last byte of each
// message and the parsed length (and its overflow flag) on the header
// terminator byte and every body byte. The block sustains one byte per clock
// while the result side is not stalling; a byte goes from its req transfer
// into a queue entry, then the output register that drives rsp. The framing
// engine sets the rate: it updates all parse state for one byte per cycle
// with a single shift-add of the LEN_WIDTH-bit length accumulator. A two-entry
// queue between classifier and engine plus the output register let req flow
// while a result waits, until the queue fills. No clearing pass follows reset.
module http_message_framer #(
   parameter int unsigned LEN_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_in_body,
   output logic        rsp_message_end,
   output logic [31:0] rsp_body_length,
   output logic        rsp_length_overflow
);
   import hmf_pkg::*;

   logic      push_valid, push_ready;
   class_type push_item;
   logic      pop_valid, pop_ready;
   class_type pop_item;

   hmf_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_item     (push_item)
   );

   hmf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   hmf_back #(
      .LEN_WIDTH (LEN_WIDTH)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .pop_valid           (pop_valid),
      .pop_ready           (pop_ready),
      .pop_item            (pop_item),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_in_body         (rsp_in_body),
      .rsp_message_end     (rsp_message_end),
      .rsp_body_length     (rsp_body_length),
      .rsp_length_overflow (rsp_length_overflow)
   );

endmodule

// File: rtl/core/hmf_front.sv
// front end: takes stream bytes and classifies each one
// depends on hmf_pkg
module hmf_front (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_data_byte,
   output logic                 push_valid,
   input  logic                 push_ready,
   output hmf_pkg::class_type   push_item
);
   import hmf_pkg::*;

   logic [7:0] b;

   assign b = req_data_byte;
   assign req_ready = push_ready;
   assign push_valid = req_valid;

   always_comb begin
      push_item.data = b;
      push_item.lower = (b inside {[8'd65:8'd90]}) ? b + 8'd32 : b;
      push_item.is_digit = b inside {[8'd48:8'd57]};
      push_item.digit = 4'(b - CHAR_ZERO);
      push_item.is_space = (b == CHAR_SPACE) || (b inside {[8'd9:8'd13]});
      push_item.is_cr = (b == CHAR_CR);
      push_item.is_lf = (b == CHAR_LF);
      push_item.is_key_start = (push_item.lower == CHAR_KEY_START);
   end

endmodule

// File: rtl/core/hmf_queue.sv
// short queue between the classifier and the framing engine
// depends on hmf_pkg
module hmf_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  hmf_pkg::class_type   push_item,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output hmf_pkg::class_type   pop_item
);
   import hmf_pkg::*;

   class_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item = entry_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   function automatic logic [QUEUE_PTR_W-1:0] ptr_next(input logic [QUEUE_PTR_W-1:0] p);
      return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/core/hmf_back.sv
// framing engine: header/body tracking, key match, length parse, output register
// depends on hmf_pkg
module hmf_back #(
   parameter int unsigned LEN_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  hmf_pkg::class_type   pop_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_in_body,
   output logic                 rsp_message_end,
   output logic [31:0]          rsp_body_length,
   output logic                 rsp_length_overflow
);
   import hmf_pkg::*;

   localparam int unsigned PROD_W = LEN_WIDTH + 4;

   phase_type             phase_ff, phase_in;
   logic [1:0]            term_ff, term_in;
   logic [3:0]            key_idx_ff, key_idx_in;
   value_state_type       vstate_ff, vstate_in;
   logic [LEN_WIDTH-1:0]  accum_ff, accum_in;
   logic                  ovf_ff, ovf_in;
   logic [LEN_WIDTH-1:0]  remain_ff, remain_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            out_byte_ff;
   logic                  in_body_ff, in_body_in;
   logic                  msg_end_ff, msg_end_in;
   logic [31:0]           length_ff, length_in;
   logic                  len_ovf_ff, len_ovf_in;

   logic                  pop;
   logic [PROD_W-1:0]     prod;
   logic [4:0]            key_next;
   logic [2:0]            term_next;
   logic                  term_hit;

   assign pop = pop_valid && (!rsp_valid_ff || rsp_ready);
   assign pop_ready = pop;

   assign prod = PROD_W'({accum_ff, 3'b000}) + PROD_W'({accum_ff, 1'b0})
                 + PROD_W'(pop_item.digit);

   assign term_hit = term_ff[0] ? pop_item.is_lf : pop_item.is_cr;

   always_comb begin
      phase_in = phase_ff;
      term_in = term_ff;
      key_idx_in = key_idx_ff;
      vstate_in = vstate_ff;
      accum_in = accum_ff;
      ovf_in = ovf_ff;
      remain_in = remain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      in_body_in = 1'b0;
      msg_end_in = 1'b0;
      length_in = '0;
      len_ovf_in = 1'b0;
      key_next = '0;
      term_next = '0;

      if (pop) begin
         rsp_valid_in = 1'b1;
         if (phase_ff == PH_BODY) begin
            in_body_in = 1'b1;
            length_in = 32'(accum_ff);
            len_ovf_in = ovf_ff;
            if (remain_ff == LEN_WIDTH'(1)) begin
               msg_end_in = 1'b1;
               phase_in = PH_HEADER;
               term_in = '0;
               key_idx_in = '0;
               vstate_in = VS_NO_KEY;
               accum_in = '0;
               ovf_in = 1'b0;
               remain_in = '0;
            end else begin
               remain_in = remain_ff - LEN_WIDTH'(1);
            end
         end else begin
            case (vstate_ff)
               VS_SKIP: begin
                  if (pop_item.is_lf && term_ff[0]) begin
                     vstate_in = VS_DONE;
                  end else if (pop_item.is_space) begin
                     vstate_in = VS_SKIP;
                  end else if (pop_item.is_digit) begin
                     accum_in = LEN_WIDTH'(pop_item.digit);
                     vstate_in = VS_DIGITS;
                  end else begin
                     accum_in = '0;
                     vstate_in = VS_DONE;
                  end
               end
               VS_DIGITS: begin
                  if (!pop_item.is_digit) begin
                     vstate_in = VS_DONE;
                  end else if (prod[PROD_W-1:LEN_WIDTH] != '0) begin
                     accum_in = '0;
                     ovf_in = 1'b1;
                     vstate_in = VS_DONE;
                  end else begin
                     accum_in = prod[LEN_WIDTH-1:0];
                  end
               end
               VS_NO_KEY: begin
                  if (pop_item.lower == key_char(key_idx_ff)) begin
                     key_next = {1'b0, key_idx_ff} + 5'd1;
                  end else begin
                     key_next = pop_item.is_key_start ? 5'd1 : 5'd0;
                  end
                  if (key_next == {1'b0, KEY_LEN}) begin
                     key_idx_in = '0;
                     vstate_in = VS_SKIP;
                     accum_in = '0;
                  end else begin
                     key_idx_in = key_next[3:0];
                  end
               end
               default: begin
                  vstate_in = vstate_ff;
               end
            endcase

            if (term_hit) begin
               term_next = {1'b0, term_ff} + 3'd1;
            end else begin
               term_next = pop_item.is_cr ? 3'd1 : 3'd0;
            end

            if (term_next == 3'd4) begin
               length_in = 32'(accum_in);
               len_ovf_in = ovf_in;
               term_in = '0;
               key_idx_in = '0;
               if (accum_in == '0) begin
                  msg_end_in = 1'b1;
                  phase_in = PH_HEADER;
                  vstate_in = VS_NO_KEY;
                  ovf_in = 1'b0;
                  remain_in = '0;
               end else begin
                  phase_in = PH_BODY;
                  remain_in = accum_in;
                  vstate_in = VS_DONE;
               end
            end else begin
               term_in = term_next[1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         term_ff <= '0;
         key_idx_ff <= '0;
         vstate_ff <= VS_NO_KEY;
         accum_ff <= '0;
         ovf_ff <= 1'b0;
         remain_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         term_ff <= term_in;
         key_idx_ff <= key_idx_in;
         vstate_ff <= vstate_in;
         accum_ff <= accum_in;
         ovf_ff <= ovf_in;
         remain_ff <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_byte_ff <= pop_item.data;
         in_body_ff <= in_body_in;
         msg_end_ff <= msg_end_in;
         length_ff <= length_in;
         len_ovf_ff <= len_ovf_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_in_body = in_body_ff;
   assign rsp_message_end = msg_end_ff;
   assign rsp_body_length = length_ff;
   assign rsp_length_overflow = len_ovf_ff;

endmodule

// File: rtl/core/hmf_checker.sv
// port-level checks on the framer result channel, bound to the top level
// depends on http_message_framer_macros.svh
`include "http_message_framer_macros.svh"

module hmf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_in_body,
   input logic        rsp_message_end,
   input logic [31:0] rsp_body_length,
   input logic        rsp_length_overflow
);

   `HMF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_byte) && $stable(rsp_in_body) && $stable(rsp_message_end) && $stable(rsp_body_length), "stalled transfer changed")
   `HMF_ASSERT_NOW(a_ovf_zero_len, clock, reset, rsp_valid && rsp_length_overflow, rsp_body_length == 32'd0, "overflow with nonzero length")
   `HMF_ASSERT_NOW(a_header_end_zero, clock, reset, rsp_valid && !rsp_in_body && rsp_message_end, rsp_body_length == 32'd0, "header-only message with length")
   `HMF_ASSERT_NOW(a_body_no_ovf, clock, reset, rsp_valid && rsp_in_body, !rsp_length_overflow, "body byte after overflowed length")

endmodule

bind http_message_framer hmf_checker u_hmf_checker (.*);
